// ----- sv/tsps_pkg.sv -----
// Shared constants and types for the transport-stream sync acquisition block.
package tsps_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int LOCK_PACKETS = 5;

    localparam int TAP_COUNT  = LOCK_PACKETS - 1;
    localparam int LINE_DEPTH = TAP_COUNT * PACKET_BYTES;
    localparam int PTR_W      = $clog2(PACKET_BYTES);
    localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
    localparam int CNT_W      = 32;

    localparam logic [7:0] SYNC_BYTE     = 8'h47;
    localparam logic [7:0] SCRAMBLE_MASK = 8'hC0;

    localparam logic [PTR_W-1:0] PHASE_FIRST    = '0;
    localparam logic [PTR_W-1:0] PHASE_SCRAMBLE = PTR_W'(3);
    localparam logic [PTR_W-1:0] PHASE_LAST     = PTR_W'(PACKET_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_FULL     = FILL_W'(LINE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_MAX        = '1;

    typedef logic [TAP_COUNT-1:0][7:0] tap_vec_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             packet_start;
        logic             packet_end;
        logic             packet_scrambled;
        logic [CNT_W-1:0] packets_passed;
        logic [CNT_W-1:0] scrambled_packets;
        logic [CNT_W-1:0] bytes_skipped;
    } result_t;

endpackage

// ----- sv/tsps_tap_line.sv -----
// Byte delay line built from chained circular RAM segments, one tap per segment.
module tsps_tap_line
    import tsps_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           shift_en,
    input  logic [7:0]     din,
    output tap_vec_t       taps
);

    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [PTR_W-1:0] rd_addr;
    tap_vec_t         rd_data_reg;

    assign ptr_next = (ptr_reg == PHASE_LAST) ? '0 : ptr_reg + PTR_W'(1);
    // Address moves with the beat so the read data is ready for the next one.
    assign rd_addr  = shift_en ? ptr_next : ptr_reg;
    assign taps     = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (shift_en) begin
            ptr_reg <= ptr_next;
        end
    end

    for (genvar g = 0; g < TAP_COUNT; g++) begin : g_seg
        logic [7:0] seg_mem [PACKET_BYTES];
        logic [7:0] wr_data;

        // Newest segment takes the incoming byte, the others take what falls out above.
        if (g == TAP_COUNT - 1) begin : g_top
            assign wr_data = din;
        end else begin : g_chain
            assign wr_data = rd_data_reg[g + 1];
        end

        always_ff @(posedge aclk) begin
            if (shift_en) begin
                seg_mem[ptr_reg] <= wr_data;
            end
            rd_data_reg[g] <= seg_mem[rd_addr];
        end
    end

endmodule

// ----- sv/ts_packet_sync_acquire.sv -----
// Transport-stream sync acquisition: hunt for five aligned 0x47 bytes, then mark packets.
//
// Input beat (s_valid/s_ready): one raw stream byte on s_data_byte.
// Result beat (m_valid/m_ready): the byte leaving the 752-byte delay line with
// packet start/end marks, a scrambled flag on the end byte and three saturating
// totals (packets passed, scrambled packets, bytes skipped).
// The first 752 bytes after reset only fill the line and give no result. While
// hunting, a byte is dropped (and counted) unless it and the bytes 188, 376, 564
// and 752 later are all 0x47. A locked packet whose first byte is not 0x47 sends
// the block back to hunting.
// Throughput: one byte per cycle while s_ready is high. The four line segments are
// circular RAMs read one beat ahead, so every tap is available in the cycle a byte
// is accepted. A result is registered into the output register, or into the skid
// entry while the output stalls. Results go through a two-entry output buffer;
// s_ready drops only when both entries are full, i.e. two results stall behind m_ready.
// Reset (aresetn low, synchronous) clears the fill count, lock state, counters
// and output buffer; RAM contents are left as they are and get flushed by the fill.
module ts_packet_sync_acquire
    import tsps_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_packet_start,
    output logic             m_packet_end,
    output logic             m_packet_scrambled,
    output logic [CNT_W-1:0] m_packets_passed,
    output logic [CNT_W-1:0] m_scrambled_packets,
    output logic [CNT_W-1:0] m_bytes_skipped
);

    tap_vec_t taps;

    logic [FILL_W-1:0] fill_reg,     fill_next;
    logic              locked_reg,   locked_next;
    logic [PTR_W-1:0]  phase_reg,    phase_next;
    logic              scramble_reg, scramble_next;
    logic [CNT_W-1:0]  passed_reg,   passed_next;
    logic [CNT_W-1:0]  scr_cnt_reg,  scr_cnt_next;
    logic [CNT_W-1:0]  skipped_reg,  skipped_next;

    result_t out_reg, skid_reg, result;
    logic    m_valid_reg, skid_valid_reg;

    logic             s_accept;
    logic             line_full;
    logic             all_sync;
    logic             locked_eff;
    logic             push;
    logic [PTR_W-1:0] ph;

    assign s_ready   = !skid_valid_reg;
    assign s_accept  = s_valid && s_ready;
    assign line_full = (fill_reg == FILL_FULL);

    tsps_tap_line u_tap_line (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (s_accept),
        .din      (s_data_byte),
        .taps     (taps)
    );

    always_comb begin
        all_sync = (s_data_byte == SYNC_BYTE);
        for (int k = 0; k < TAP_COUNT; k++) begin
            if (taps[k] != SYNC_BYTE) begin
                all_sync = 1'b0;
            end
        end
    end

    always_comb begin
        fill_next     = fill_reg;
        locked_next   = locked_reg;
        phase_next    = phase_reg;
        scramble_next = scramble_reg;
        passed_next   = passed_reg;
        scr_cnt_next  = scr_cnt_reg;
        skipped_next  = skipped_reg;
        push          = 1'b0;

        // A packet whose sync byte is missing drops lock and is re-tested as hunting.
        locked_eff = locked_reg && !(phase_reg == PHASE_FIRST && taps[0] != SYNC_BYTE);
        ph         = locked_eff ? phase_reg : PHASE_FIRST;

        result.out_byte         = taps[0];
        result.packet_start     = (ph == PHASE_FIRST);
        result.packet_end       = (ph == PHASE_LAST);
        result.packet_scrambled = (ph == PHASE_LAST) && scramble_reg;

        if (s_accept) begin
            if (!line_full) begin
                fill_next = fill_reg + FILL_W'(1);
            end else if (!locked_eff && !all_sync) begin
                locked_next = 1'b0;
                phase_next  = PHASE_FIRST;
                if (skipped_reg != CNT_MAX) begin
                    skipped_next = skipped_reg + CNT_W'(1);
                end
            end else begin
                push        = 1'b1;
                locked_next = 1'b1;
                if (ph == PHASE_FIRST) begin
                    scramble_next = 1'b0;
                end
                if (ph == PHASE_SCRAMBLE) begin
                    scramble_next = |(taps[0] & SCRAMBLE_MASK);
                end
                if (ph == PHASE_LAST) begin
                    phase_next = PHASE_FIRST;
                    if (passed_reg != CNT_MAX) begin
                        passed_next = passed_reg + CNT_W'(1);
                    end
                    if (scramble_reg && scr_cnt_reg != CNT_MAX) begin
                        scr_cnt_next = scr_cnt_reg + CNT_W'(1);
                    end
                end else begin
                    phase_next = ph + PTR_W'(1);
                end
            end
        end

        result.packets_passed    = passed_next;
        result.scrambled_packets = scr_cnt_next;
        result.bytes_skipped     = skipped_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            locked_reg   <= 1'b0;
            phase_reg    <= '0;
            scramble_reg <= 1'b0;
            passed_reg   <= '0;
            scr_cnt_reg  <= '0;
            skipped_reg  <= '0;
        end else begin
            fill_reg     <= fill_next;
            locked_reg   <= locked_next;
            phase_reg    <= phase_next;
            scramble_reg <= scramble_next;
            passed_reg   <= passed_next;
            scr_cnt_reg  <= scr_cnt_next;
            skipped_reg  <= skipped_next;
        end
    end

    // Output register plus skid entry; a stalled result parks the next one in skid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end else if (push) begin
            skid_reg <= result;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_out_byte          = out_reg.out_byte;
    assign m_packet_start      = out_reg.packet_start;
    assign m_packet_end        = out_reg.packet_end;
    assign m_packet_scrambled  = out_reg.packet_scrambled;
    assign m_packets_passed    = out_reg.packets_passed;
    assign m_scrambled_packets = out_reg.scrambled_packets;
    assign m_bytes_skipped     = out_reg.bytes_skipped;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry valid while output register empty");

    a_no_result_while_filling: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> line_full)
        else $error("result produced before delay line filled");

    a_hunt_phase_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !locked_reg |-> phase_reg == PHASE_FIRST)
        else $error("packet phase advanced while hunting");

    a_scrambled_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_packet_scrambled) |-> m_packet_end)
        else $error("scrambled flag off the packet end beat");

    a_passed_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && result.packet_end && passed_reg != CNT_MAX)
            |=> passed_reg == $past(passed_reg) + CNT_W'(1))
        else $error("packet count missed an end beat");
`endif

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the transport-stream packet sync acquisition block.
module tb_top;
    import tsps_pkg::*;

    localparam int MAX_GAP        = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {PAY_RANDOM, PAY_ZERO, PAY_ONES, PAY_SYNC} payload_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [7:0]       s_data_byte;
    logic             m_valid;
    logic             m_ready;
    logic [7:0]       m_out_byte;
    logic             m_packet_start;
    logic             m_packet_end;
    logic             m_packet_scrambled;
    logic [CNT_W-1:0] m_packets_passed;
    logic [CNT_W-1:0] m_scrambled_packets;
    logic [CNT_W-1:0] m_bytes_skipped;

    ts_packet_sync_acquire i_dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Sync tracker state, mirrors the block's delay line and lock logic
    logic [7:0]       line_mem [LINE_DEPTH] = '{default: 8'h00};
    int               line_head      = 0;
    int               line_fill      = 0;
    int               pkt_phase      = 0;
    bit               sync_locked    = 1'b0;
    bit               ctrl_scrambled = 1'b0;
    logic [CNT_W-1:0] passed_cnt     = '0;
    logic [CNT_W-1:0] scrambled_cnt  = '0;
    logic [CNT_W-1:0] skipped_cnt    = '0;
    result_t          aligned_bytes_due [$];

    int fail_count    = 0;
    int stall_cycles  = 0;
    int sink_hold_req = 0;
    bit src_steady    = 1'b0;
    bit snk_steady    = 1'b0;

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    // incoming byte plus the oldest byte and every packet-spaced tap must be sync
    function automatic bit taps_sync(logic [7:0] incoming);
        if (incoming != SYNC_BYTE)
            return 1'b0;
        for (int k = 0; k < TAP_COUNT; k++) begin
            if (line_mem[(line_head + k * PACKET_BYTES) % LINE_DEPTH] != SYNC_BYTE)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_aligned_byte(logic [7:0] incoming);
        logic [7:0] oldest;
        result_t    beat;
        if (line_fill < LINE_DEPTH) begin
            line_mem[line_fill] = incoming;
            line_fill++;
            return;
        end
        oldest = line_mem[line_head];
        if (sync_locked && pkt_phase == 0 && oldest != SYNC_BYTE)
            sync_locked = 1'b0;
        if (!sync_locked) begin
            if (taps_sync(incoming)) begin
                sync_locked = 1'b1;
                pkt_phase   = 0;
            end else begin
                skipped_cnt = sat_inc(skipped_cnt);
            end
        end
        if (sync_locked) begin
            beat = '0;
            beat.out_byte = oldest;
            if (pkt_phase == 0) begin
                beat.packet_start = 1'b1;
                ctrl_scrambled    = 1'b0;
            end
            if (pkt_phase == int'(PHASE_SCRAMBLE))
                ctrl_scrambled = (oldest & SCRAMBLE_MASK) != 8'h00;
            if (pkt_phase >= int'(PHASE_LAST)) begin
                beat.packet_end       = 1'b1;
                beat.packet_scrambled = ctrl_scrambled;
                passed_cnt = sat_inc(passed_cnt);
                if (ctrl_scrambled)
                    scrambled_cnt = sat_inc(scrambled_cnt);
                pkt_phase = 0;
            end else begin
                pkt_phase++;
            end
            beat.packets_passed    = passed_cnt;
            beat.scrambled_packets = scrambled_cnt;
            beat.bytes_skipped     = skipped_cnt;
            aligned_bytes_due.push_back(beat);
        end
        line_mem[line_head] = incoming;
        line_head = (line_head + 1) % LINE_DEPTH;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_aligned_byte(b);
    endtask

    task automatic send_packet(input logic [7:0] first, input logic [7:0] ctrl,
                               input payload_t pay, input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (pay)
                PAY_ZERO: b = 8'h00;
                PAY_ONES: b = 8'hFF;
                PAY_SYNC: b = SYNC_BYTE;
                default:  b = 8'($urandom);
            endcase
            if (i == 0)
                b = first;
            else if (i == 3)
                b = ctrl;
            send_byte(b);
        end
    endtask

    task automatic send_good_packets(input int n);
        for (int i = 0; i < n; i++)
            send_packet(SYNC_BYTE, 8'($urandom), PAY_RANDOM, PACKET_BYTES);
    endtask

    task automatic send_garbage(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom));
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (aligned_bytes_due.size() != 0)
            @(posedge aclk);
    endtask

    // seven stray bytes go into the fill and are skipped while hunting, then lock on the fifth start,
    // all control-bit patterns on the packets
    task automatic test_line_fill();
        src_steady = 1'b1;
        snk_steady = 1'b1;
        send_garbage(7);
        send_packet(SYNC_BYTE, 8'h00, PAY_ZERO, PACKET_BYTES);
        send_packet(SYNC_BYTE, 8'hFF, PAY_ONES, PACKET_BYTES);
        send_packet(SYNC_BYTE, 8'h40, PAY_RANDOM, PACKET_BYTES);
        send_packet(SYNC_BYTE, 8'h80, PAY_SYNC, PACKET_BYTES);
        send_packet(SYNC_BYTE, 8'hC0, PAY_ZERO, PACKET_BYTES);
        src_steady = 1'b0;
        snk_steady = 1'b0;
        wait_results_done();
    endtask

    // bad sync byte on a locked packet: lock drops and the whole packet is skipped
    task automatic test_lost_sync();
        send_packet(8'h46, 8'h80, PAY_RANDOM, PACKET_BYTES);
        send_good_packets(4);
        wait_results_done();
    endtask

    // receiver stops for a long stretch while the next start relocks; input must back up
    task automatic test_sink_hold();
        src_steady    = 1'b1;
        sink_hold_req = HOLD_CYCLES;
        send_good_packets(1);
        src_steady = 1'b0;
        wait_results_done();
    endtask

    initial begin : result_sink
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (sink_hold_req > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold_req) @(posedge aclk);
                sink_hold_req = 0;
            end
            gap = snk_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (aligned_bytes_due.size() == 0) begin
                $error("result beat with nothing expected, out_byte %0h", m_out_byte);
                fail_count++;
            end else begin
                want = aligned_bytes_due.pop_front();
                check_field("out_byte", CNT_W'(want.out_byte), CNT_W'(m_out_byte));
                check_field("packet_start", CNT_W'(want.packet_start),
                            CNT_W'(m_packet_start));
                check_field("packet_end", CNT_W'(want.packet_end), CNT_W'(m_packet_end));
                check_field("packet_scrambled", CNT_W'(want.packet_scrambled),
                            CNT_W'(m_packet_scrambled));
                check_field("packets_passed", want.packets_passed, m_packets_passed);
                check_field("scrambled_packets", want.scrambled_packets,
                            m_scrambled_packets);
                check_field("bytes_skipped", want.bytes_skipped, m_bytes_skipped);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : test_sequence
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_data_byte <= 8'h00;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_line_fill();
        test_lost_sync();
        test_sink_hold();
        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && aligned_bytes_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
